[sv/usr_pkg.sv]
// usr_pkg: shared types, codes and constants of the ultrasonic scan ranger
// no dependencies; imported by every module of the block

package usr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input function codes
    localparam logic [2:0] FUNC_ECHO  = 3'd0;
    localparam logic [2:0] FUNC_TICK  = 3'd1;
    localparam logic [2:0] FUNC_START = 3'd2;
    localparam logic [2:0] FUNC_MODE  = 3'd3;
    localparam logic [2:0] FUNC_POT   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ECHO  = 2'd3;

    localparam logic [7:0]  DWELL_RST    = 8'd40;
    localparam logic [7:0]  BLINK_RST    = 8'd10;
    localparam logic [15:0] MAX_ECHO_RST = 16'd38000;
    localparam logic [7:0]  NO_ECHO_RST  = 8'd200;

    // width / 58 as (width * CM_RECIP) >> CM_SHIFT, exact for 16-bit widths
    localparam logic [16:0] CM_RECIP = 17'd72316;
    localparam int          CM_SHIFT = 22;
    // pot * 1000 / 4095 as (pot * POT_RECIP) >> POT_SHIFT, exact for 12-bit pot
    localparam logic [31:0] POT_RECIP = 32'd4195329000;
    localparam int          POT_SHIFT = 34;

    localparam logic [10:0] SERVO_MIN    = 11'd1000;
    localparam logic [10:0] SERVO_CENTER = 11'd1500;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] capture_time;
        logic [11:0] pot_sample;
    } usr_in_t;

    typedef struct packed {
        logic [7:0]  dist_cm;
        logic        distance_new;
        logic [2:0]  bar_level;
        logic [10:0] servo_pulse_us;
        logic        fire_trigger;
        logic        busy_led;
        logic        auto_mode;
        logic        report_valid;
        logic [2:0]  report_slot;
        logic [7:0]  report_distance;
        logic        last;
    } usr_out_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic apply;
        logic rpt_step;
    } usr_cmd_t;

    typedef struct packed {
        logic rpt_valid;
        logic rpt_final;
    } usr_sts_t;

    function automatic logic [2:0] bar_of(input logic [7:0] d);
        logic [2:0] lvl;
        if (d <= 8'd10) begin
            lvl = 3'd5;
        end else if (d <= 8'd20) begin
            lvl = 3'd4;
        end else if (d <= 8'd40) begin
            lvl = 3'd3;
        end else if (d <= 8'd60) begin
            lvl = 3'd2;
        end else if (d <= 8'd80) begin
            lvl = 3'd1;
        end else begin
            lvl = 3'd0;
        end
        return lvl;
    endfunction

endpackage

[sv/usr_datapath.sv]
// usr_datapath: configuration registers, ranging state, scan store, multipliers
// and the result register view of the ultrasonic scan ranger
// depends on usr_pkg; driven by usr_ctrl through usr_cmd_t

module usr_datapath #(
    parameter int SCAN_POINTS = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [usr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [usr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  usr_pkg::usr_in_t              s_data,
    output usr_pkg::usr_out_t             m_data,
    input  usr_pkg::usr_cmd_t             cmd,
    output usr_pkg::usr_sts_t             sts
);
    import usr_pkg::*;

    localparam int SlotIdxW = (SCAN_POINTS > 1) ? $clog2(SCAN_POINTS) : 1;
    localparam logic [2:0] LastSlot = 3'(SCAN_POINTS - 1);
    localparam logic [3:0] NumSlots = 4'(SCAN_POINTS);

    // servo pulse of each scan position
    logic [10:0] slot_pulse_tab [8];
    for (genvar g = 0; g < 8; g++) begin : g_pulse
        localparam int Angle    = -90 + (180 * g) / (SCAN_POINTS - 1);
        localparam int RawPulse = 1500 + (Angle * 500) / 90;
        localparam int Pulse    = (RawPulse < 1000) ? 1000 :
                                  ((RawPulse > 2000) ? 2000 : RawPulse);
        assign slot_pulse_tab[g] = 11'(Pulse);
    end

    logic [7:0]  dwell_ticks_reg;
    logic [7:0]  blink_ticks_reg;
    logic [15:0] max_echo_reg;
    logic [7:0]  no_echo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg <= DWELL_RST;
            blink_ticks_reg <= BLINK_RST;
            max_echo_reg    <= MAX_ECHO_RST;
            no_echo_reg     <= NO_ECHO_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DWELL:    dwell_ticks_reg <= cfg_wdata[7:0];
                CFG_BLINK:    blink_ticks_reg <= cfg_wdata[7:0];
                CFG_MAX_ECHO: max_echo_reg    <= cfg_wdata;
                CFG_NO_ECHO:  no_echo_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input transaction and products
    usr_in_t     in_reg;
    logic [15:0] width_now;
    logic [15:0] width_reg;
    logic [32:0] cm_prod_reg;
    logic [43:0] pot_prod_reg;

    logic        mode_auto_reg, mode_auto_next;
    logic        scanning_reg, scanning_next;
    logic        blinking_reg, blinking_next;
    logic        tick_en_reg, tick_en_next;
    logic        lamp_reg, lamp_next;
    logic        await_fall_reg, await_fall_next;
    logic [15:0] rise_reg, rise_next;
    logic [7:0]  blink_cnt_reg, blink_cnt_next;
    logic [7:0]  dwell_cnt_reg, dwell_cnt_next;
    logic [2:0]  scan_slot_reg, scan_slot_next;
    logic [7:0]  last_dist_reg, last_dist_next;
    logic [10:0] servo_reg, servo_next;
    logic        dnew_reg, dnew_next;
    logic        fire_reg, fire_next;
    logic        rpt_valid_reg, rpt_valid_next;
    logic [2:0]  rpt_idx_reg, rpt_idx_next;

    logic [7:0]  store_reg [SCAN_POINTS];
    logic        store_clr;
    logic        store_we;
    logic [7:0]  store_wdata;

    // echo width wraps at 16 bits
    assign width_now = in_reg.capture_time - rise_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.mul) begin
            width_reg    <= width_now;
            cm_prod_reg  <= 33'(width_now) * 33'(CM_RECIP);
            pot_prod_reg <= 44'(in_reg.pot_sample) * 44'(POT_RECIP);
        end
    end

    logic [10:0] cm_quot;
    logic [7:0]  echo_dist;
    logic [10:0] pot_servo;
    logic [7:0]  blink_inc;
    logic [7:0]  dwell_inc;

    assign cm_quot   = cm_prod_reg[32:CM_SHIFT];
    assign echo_dist = (width_reg > max_echo_reg) ? no_echo_reg :
                       ((cm_quot > 11'd255) ? 8'hFF : cm_quot[7:0]);
    assign pot_servo = SERVO_MIN + 11'(pot_prod_reg[43:POT_SHIFT]);
    assign blink_inc = (blink_cnt_reg != 8'hFF) ? blink_cnt_reg + 8'd1 : blink_cnt_reg;
    assign dwell_inc = dwell_cnt_reg + 8'd1;

    always_comb begin
        mode_auto_next  = mode_auto_reg;
        scanning_next   = scanning_reg;
        blinking_next   = blinking_reg;
        tick_en_next    = tick_en_reg;
        lamp_next       = lamp_reg;
        await_fall_next = await_fall_reg;
        rise_next       = rise_reg;
        blink_cnt_next  = blink_cnt_reg;
        dwell_cnt_next  = dwell_cnt_reg;
        scan_slot_next  = scan_slot_reg;
        last_dist_next  = last_dist_reg;
        servo_next      = servo_reg;
        dnew_next       = dnew_reg;
        fire_next       = fire_reg;
        rpt_valid_next  = rpt_valid_reg;
        rpt_idx_next    = rpt_idx_reg;
        store_clr       = 1'b0;
        store_we        = 1'b0;
        store_wdata     = (echo_dist >= no_echo_reg) ? no_echo_reg : echo_dist;
        if (cmd.apply) begin
            dnew_next      = 1'b0;
            fire_next      = 1'b0;
            rpt_valid_next = 1'b0;
            rpt_idx_next   = 3'd0;
            case (in_reg.func)
                FUNC_ECHO: begin
                    if (!await_fall_reg) begin
                        rise_next       = in_reg.capture_time;
                        await_fall_next = 1'b1;
                    end else begin
                        await_fall_next = 1'b0;
                        last_dist_next  = echo_dist;
                        dnew_next       = 1'b1;
                        store_we = mode_auto_reg && scanning_reg &&
                                   (4'(scan_slot_reg) < NumSlots);
                    end
                end
                FUNC_TICK: begin
                    if (tick_en_reg) begin
                        blink_cnt_next = blink_inc;
                        if (!mode_auto_reg) begin
                            if (blink_inc >= blink_ticks_reg) begin
                                lamp_next    = 1'b0;
                                tick_en_next = 1'b0;
                            end
                        end else if (blinking_reg) begin
                            if (blink_inc >= blink_ticks_reg) begin
                                lamp_next      = !lamp_reg;
                                blink_cnt_next = 8'd0;
                            end
                            if (scanning_reg) begin
                                dwell_cnt_next = dwell_inc;
                                if (dwell_inc >= dwell_ticks_reg) begin
                                    dwell_cnt_next = 8'd0;
                                    if ((4'(scan_slot_reg) + 4'd1) < NumSlots) begin
                                        scan_slot_next = scan_slot_reg + 3'd1;
                                        servo_next = slot_pulse_tab[scan_slot_reg + 3'd1];
                                        fire_next  = 1'b1;
                                    end else begin
                                        // sweep done, report every slot
                                        scanning_next  = 1'b0;
                                        blinking_next  = 1'b0;
                                        servo_next     = SERVO_CENTER;
                                        lamp_next      = 1'b0;
                                        rpt_valid_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                FUNC_START: begin
                    blink_cnt_next = 8'd0;
                    tick_en_next   = 1'b1;
                    fire_next      = 1'b1;
                    if (!mode_auto_reg) begin
                        lamp_next     = 1'b1;
                        blinking_next = 1'b0;
                    end else begin
                        blinking_next  = 1'b1;
                        scanning_next  = 1'b1;
                        scan_slot_next = 3'd0;
                        dwell_cnt_next = 8'd0;
                        store_clr      = 1'b1;
                        servo_next     = slot_pulse_tab[0];
                    end
                end
                FUNC_MODE: begin
                    if (!scanning_reg) begin
                        mode_auto_next = !mode_auto_reg;
                    end
                end
                FUNC_POT: begin
                    if (!mode_auto_reg) begin
                        servo_next = pot_servo;
                    end
                end
                default: ;
            endcase
        end else if (cmd.rpt_step) begin
            rpt_idx_next = rpt_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_auto_reg  <= 1'b0;
            scanning_reg   <= 1'b0;
            blinking_reg   <= 1'b0;
            tick_en_reg    <= 1'b1;
            lamp_reg       <= 1'b0;
            await_fall_reg <= 1'b0;
            rise_reg       <= 16'd0;
            blink_cnt_reg  <= 8'd0;
            dwell_cnt_reg  <= 8'd0;
            scan_slot_reg  <= 3'd0;
            last_dist_reg  <= 8'd0;
            servo_reg      <= SERVO_CENTER;
            dnew_reg       <= 1'b0;
            fire_reg       <= 1'b0;
            rpt_valid_reg  <= 1'b0;
            rpt_idx_reg    <= 3'd0;
        end else begin
            mode_auto_reg  <= mode_auto_next;
            scanning_reg   <= scanning_next;
            blinking_reg   <= blinking_next;
            tick_en_reg    <= tick_en_next;
            lamp_reg       <= lamp_next;
            await_fall_reg <= await_fall_next;
            rise_reg       <= rise_next;
            blink_cnt_reg  <= blink_cnt_next;
            dwell_cnt_reg  <= dwell_cnt_next;
            scan_slot_reg  <= scan_slot_next;
            last_dist_reg  <= last_dist_next;
            servo_reg      <= servo_next;
            dnew_reg       <= dnew_next;
            fire_reg       <= fire_next;
            rpt_valid_reg  <= rpt_valid_next;
            rpt_idx_reg    <= rpt_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || store_clr) begin
            for (int i = 0; i < SCAN_POINTS; i++) begin
                store_reg[i] <= 8'd0;
            end
        end else if (store_we) begin
            store_reg[scan_slot_reg[SlotIdxW-1:0]] <= store_wdata;
        end
    end

    always_comb begin
        m_data.dist_cm         = last_dist_reg;
        m_data.distance_new    = dnew_reg;
        m_data.bar_level       = bar_of(last_dist_reg);
        m_data.servo_pulse_us  = servo_reg;
        m_data.fire_trigger    = fire_reg;
        m_data.busy_led        = lamp_reg;
        m_data.auto_mode       = mode_auto_reg;
        m_data.report_valid    = rpt_valid_reg;
        m_data.report_slot     = rpt_valid_reg ? rpt_idx_reg : 3'd0;
        m_data.report_distance = rpt_valid_reg ? store_reg[rpt_idx_reg[SlotIdxW-1:0]] : 8'd0;
        m_data.last            = !rpt_valid_reg || (rpt_idx_reg == LastSlot);
    end

    assign sts.rpt_valid = rpt_valid_reg;
    assign sts.rpt_final = (rpt_idx_reg == LastSlot);

endmodule

[sv/usr_ctrl.sv]
// usr_ctrl: transaction sequencer of the ultrasonic scan ranger
// depends on usr_pkg; commands usr_datapath through usr_cmd_t

module usr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output usr_pkg::usr_cmd_t cmd,
    input  usr_pkg::usr_sts_t sts
);
    import usr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (!sts.rpt_valid || sts.rpt_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rpt_step = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);

endmodule

[sv/ultrasonic_scan_ranger.sv]
// ultrasonic scan ranger: one input transaction at a time; an accepted transaction
// passes through load, multiply and state update before the first result
// a status transaction yields a single result; a sweep-ending tick yields one
// report result per scan slot, each held while m_ready is low
// aresetn is synchronous, active low, and restores the state and configuration registers
// depends on usr_pkg, usr_ctrl, usr_datapath

module ultrasonic_scan_ranger #(
    parameter int SCAN_POINTS = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [usr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [usr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  usr_pkg::usr_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output usr_pkg::usr_out_t              m_data
);
    import usr_pkg::*;

    usr_cmd_t cmd;
    usr_sts_t sts;

    usr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    usr_datapath #(
        .SCAN_POINTS (SCAN_POINTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[sv/usr_checker.sv]
// usr_checker: port-level assertions for the ultrasonic scan ranger
// depends on usr_pkg; bound to ultrasonic_scan_ranger at the end of this file

module usr_checker #(
    parameter int SCAN_POINTS = 5
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input usr_pkg::usr_out_t m_data
);
    import usr_pkg::*;

    localparam logic [2:0] LastSlot = 3'(SCAN_POINTS - 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction in flight
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // fixed latency to the first result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##3 m_valid)
        else $error("result missing three cycles after input transaction");

    // report sequence ends on the final slot
    a_rpt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.report_valid && m_data.last |-> m_data.report_slot == LastSlot)
        else $error("report ended before the final slot");

    // status result is single and carries no report
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.report_valid |->
            m_data.last && m_data.report_slot == 3'd0 && m_data.report_distance == 8'd0)
        else $error("malformed status result");

endmodule

bind ultrasonic_scan_ranger usr_checker #(
    .SCAN_POINTS (SCAN_POINTS)
) u_usr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
